FILE: rtl/core/bba_pkg.sv
// Shared types and constants for the bitmap block allocator.
// Holds stream field widths, request/status codes, FSM states and the
// command/status bundles between controller and datapath. No dependencies.
package bba_pkg;

  // Default sizing of the block store
  localparam int NUM_BLOCKS_DEF = 256;
  localparam int ID_BITS_DEF    = 8;

  // Stream payload widths (fields packed from bit 0, padded to bytes)
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 24;

  // Field widths
  localparam int MODE_W      = 2;
  localparam int FILE_ID_W   = 8;
  localparam int COUNT_W     = 9;
  localparam int ENTRY_IDX_W = 8;
  localparam int STATUS_W    = 2;
  localparam int OWNER_W     = 8;

  // Request kinds
  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC = 2'd0,
    MODE_FREE  = 2'd1,
    MODE_READ  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE     = 2'd0,
    ST_NOSPACE  = 2'd1,
    ST_NOTFOUND = 2'd2
  } status_t;

  // Controller states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_DRAIN,
    S_READ,
    S_DONE
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic clr_en;
    logic capture;
    logic scan_en;
    logic read_en;
    logic set_nospace;
    logic load_out;
  } bba_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    mode_t new_mode;
    logic  ptr_last;
    logic  fits;
  } bba_stat_t;

endpackage

FILE: rtl/core/bba_ctrl.sv
// Controller FSM of the bitmap block allocator: clearing pass, request
// dispatch, table scan sequencing and output register handshake.
// Depends on bba_pkg.
module bba_ctrl
  import bba_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  output logic      out_tvalid,
  input  logic      out_tready,
  input  bba_stat_t stat,
  output bba_cmd_t  cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // State and output valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    cmd       = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (stat.ptr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          case (stat.new_mode)
            MODE_ALLOC: state_nxt = S_CHECK;
            MODE_FREE:  state_nxt = S_SCAN;
            MODE_READ:  state_nxt = S_READ;
            default:    state_nxt = S_DONE;
          endcase
        end
      end
      S_CHECK: begin
        if (stat.fits) begin
          state_nxt = S_SCAN;
        end else begin
          cmd.set_nospace = 1'b1;
          state_nxt       = S_DONE;
        end
      end
      S_SCAN: begin
        cmd.scan_en = 1'b1;
        if (stat.ptr_last) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        // last entry writes back this cycle
        state_nxt = S_DONE;
      end
      S_READ: begin
        cmd.read_en = 1'b1;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  // Hold the result until the receiver takes it
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  assign out_tvalid = out_valid_r;

endmodule

FILE: rtl/core/bba_datapath.sv
// Datapath of the bitmap block allocator: block table memory, scan pointer,
// read-modify-write stage, free counter and output register.
// Depends on bba_pkg.
module bba_datapath
  import bba_pkg::*;
#(
  parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
  parameter int ID_BITS    = ID_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  bba_cmd_t              cmd,
  output bba_stat_t             stat
);

  localparam int IDX_W = $clog2(NUM_BLOCKS);
  localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
  localparam int CMP_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
  localparam int ENT_W = ID_BITS + 1;

  // Block table: {used, owner}
  logic [ENT_W-1:0] mem [NUM_BLOCKS];

  // Request registers
  mode_t                  mode_r;
  logic [ID_BITS-1:0]     id_r;
  logic [COUNT_W-1:0]     want_r;
  logic [ENTRY_IDX_W-1:0] idx_r;
  logic                   nospace_r;

  // Scan and counters
  logic [IDX_W-1:0] ptr_r, ptr_nxt;
  logic             chk_vld_r;
  logic [IDX_W-1:0] chk_addr_r;
  logic [ENT_W-1:0] rd_data_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] free_total_r, free_total_nxt;
  logic [OUT_DATA_W-1:0] out_data_r;

  // Input field unpacking
  mode_t                  in_mode;
  logic [FILE_ID_W-1:0]   in_file_id;
  logic [COUNT_W-1:0]     in_count;
  logic [ENTRY_IDX_W-1:0] in_idx;
  logic [15:0]            fid_wide;

  assign in_mode    = mode_t'(in_tdata[1:0]);
  assign in_file_id = in_tdata[9:2];
  assign in_count   = in_tdata[18:10];
  assign in_idx     = in_tdata[26:19];
  assign fid_wide   = 16'(in_file_id);

  // Capture the request
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r <= in_mode;
      id_r   <= fid_wide[ID_BITS-1:0];
      want_r <= in_count;
      idx_r  <= in_idx;
    end
  end

  // Read index range check
  logic [31:0]      idx_wide;
  logic             idx_in_range;
  logic [IDX_W-1:0] idx_addr;

  assign idx_wide     = 32'(idx_r);
  assign idx_in_range = idx_wide < 32'(NUM_BLOCKS);
  assign idx_addr     = idx_wide[IDX_W-1:0];

  // Scan pointer wraps to zero after the last entry
  assign stat.ptr_last = (ptr_r == IDX_W'(NUM_BLOCKS - 1));
  assign stat.new_mode = in_mode;
  assign stat.fits     = CMP_W'(want_r) <= CMP_W'(free_total_r);

  always_comb begin
    ptr_nxt = ptr_r;
    if (cmd.clr_en || cmd.scan_en) begin
      ptr_nxt = stat.ptr_last ? '0 : ptr_r + 1'b1;
    end
  end

  // Read port: scan pointer or read index
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;

  assign rd_en   = cmd.scan_en | cmd.read_en;
  assign rd_addr = cmd.read_en ? idx_addr : ptr_r;

  // Check stage decisions on the entry read last cycle
  logic               chk_used;
  logic [ID_BITS-1:0] chk_owner;
  logic               alloc_hit, free_hit, hit;

  assign chk_used  = rd_data_r[ID_BITS];
  assign chk_owner = rd_data_r[ID_BITS-1:0];
  assign alloc_hit = (mode_r == MODE_ALLOC) && !chk_used &&
                     (CMP_W'(cnt_r) < CMP_W'(want_r));
  assign free_hit  = (mode_r == MODE_FREE) && chk_used && (chk_owner == id_r);
  assign hit       = chk_vld_r && (alloc_hit || free_hit);

  // Write port: clearing pass or check stage update
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [ENT_W-1:0] wr_data;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ptr_r;
    wr_data = '0;
    if (cmd.clr_en) begin
      wr_en = 1'b1;
    end else if (hit) begin
      wr_en   = 1'b1;
      wr_addr = chk_addr_r;
      wr_data = alloc_hit ? {1'b1, id_r} : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data_r <= mem[rd_addr];
    chk_addr_r <= ptr_r;
  end

  // Hit counter and free count
  always_comb begin
    cnt_nxt        = cnt_r;
    free_total_nxt = free_total_r;
    if (cmd.capture) begin
      cnt_nxt = '0;
    end else if (hit) begin
      cnt_nxt        = cnt_r + 1'b1;
      free_total_nxt = alloc_hit ? free_total_r - 1'b1 : free_total_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r        <= '0;
      chk_vld_r    <= 1'b0;
      cnt_r        <= '0;
      free_total_r <= CNT_W'(NUM_BLOCKS);
      nospace_r    <= 1'b0;
    end else begin
      ptr_r        <= ptr_nxt;
      chk_vld_r    <= cmd.scan_en;
      cnt_r        <= cnt_nxt;
      free_total_r <= free_total_nxt;
      if (cmd.capture) nospace_r <= 1'b0;
      else if (cmd.set_nospace) nospace_r <= 1'b1;
    end
  end

  // Result assembly
  status_t           res_status;
  logic [31:0]       free_wide;
  logic              res_used;
  logic [15:0]       own_wide;
  logic [OWNER_W-1:0] res_owner;

  always_comb begin
    if (nospace_r) res_status = ST_NOSPACE;
    else if (mode_r == MODE_FREE && cnt_r == '0) res_status = ST_NOTFOUND;
    else res_status = ST_DONE;
  end

  assign free_wide = 32'(free_total_r);
  assign res_used  = (mode_r == MODE_READ) && idx_in_range && chk_used;
  assign own_wide  = 16'(chk_owner);
  assign res_owner = res_used ? own_wide[OWNER_W-1:0] : '0;

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r <= {4'b0, res_owner, res_used, free_wide[COUNT_W-1:0], res_status};
    end
  end

  assign out_tdata = out_data_r;

endmodule

FILE: rtl/core/bitmap_block_allocator.sv
// Bitmap block allocator, top level.
// Slave stream takes requests, master stream returns one result per request.
// in_tdata : mode[1:0], file_id[9:2], block_count[18:10], entry_index[26:19]
// out_tdata: status[1:0], free_blocks[10:2], entry_used[11], entry_owner[19:12]
// Requests: allocate (claims free blocks lowest index first, all or none),
// free (releases every used block of a file id), read (returns one entry).
// After reset a clearing pass marks all NUM_BLOCKS blocks free, one per
// cycle; in_tready stays low during that pass. The scan reads and updates
// one table entry per cycle through the single read and write port of the
// block table. One request is in work at a time; a new request is taken as
// soon as the previous one reaches the output register, even while that
// result waits. A stalled receiver holds the result and the block waits at
// the end of its next request until the output register frees up.
// Depends on bba_pkg, bba_ctrl and bba_datapath.
module bitmap_block_allocator
  import bba_pkg::*;
#(
  parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
  parameter int ID_BITS    = ID_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // mode[1:0], file_id[9:2], block_count[18:10], entry_index[26:19]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // status[1:0], free_blocks[10:2], entry_used[11], entry_owner[19:12]
  output logic [OUT_DATA_W-1:0] out_tdata
);

  bba_cmd_t  cmd;
  bba_stat_t stat;

  bba_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  bba_datapath #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .ID_BITS    (ID_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .out_tdata (out_tdata),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule
